### rtl/pfa_pkg.sv
// Shared types, codes and widths of the page frame allocator.
package pfa_pkg;

  localparam int NUM_PAGES_DEF = 1024;
  localparam int REF_WIDTH_DEF = 16;

  localparam int CMD_W      = 2;
  localparam int PAGE_IDX_W = 10;
  localparam int CFG_W      = 11;
  localparam int STATUS_W   = 3;
  localparam int REF_OUT_W  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT   = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_DECREF = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK           = 3'd0,
    STAT_NOMEM        = 3'd1,
    STAT_REFERENCED   = 3'd2,
    STAT_ALREADY_FREE = 3'd3,
    STAT_UNDERFLOW    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_EXEC
  } state_e;

endpackage

### rtl/pfa_req_if.sv
// Request channel of the page frame allocator: command and page index.
interface pfa_req_if;
  import pfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [PAGE_IDX_W-1:0] page_index;

  modport source (output valid, cmd, page_index, input ready);
  modport sink   (input valid, cmd, page_index, output ready);
endinterface

### rtl/pfa_rsp_if.sv
// Response channel of the page frame allocator: status, page and count.
interface pfa_rsp_if;
  import pfa_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [STATUS_W-1:0]   status;
  logic [PAGE_IDX_W-1:0] result_page;
  logic [REF_OUT_W-1:0]  ref_count_after;

  modport source (output valid, status, result_page, ref_count_after, input ready);
  modport sink   (input valid, status, result_page, ref_count_after, output ready);
endinterface

### rtl/pfa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/page_frame_allocator.sv
// Page frame allocator: per-page reference counts and a LIFO free stack.
//
//  channel  | dir | handshake         | beat contents
//  ---------+-----+-------------------+---------------------------------------
//  req_i    | in  | valid/ready       | cmd, page_index
//  rsp_o    | out | valid/ready       | status, result_page, ref_count_after
//  cfg      | in  | cfg_we_i (no wait)| first_free_page
//
// Alloc, free and decref first read the page-state RAM and the free-stack RAM,
// then do one read-modify-write of both.
// Init runs the accept step, one page-state write per page (with a push for each
// page at or above first_free_page), then the result step.
// After reset a clearing pass zeroes every entry of the page-state RAM;
// req_i.ready stays low during it.
// A result waits in the output register while the next beat is taken; the
// sequencer holds in its execute step until that register is free.
module page_frame_allocator #(
  parameter int NUM_PAGES = pfa_pkg::NUM_PAGES_DEF,
  parameter int REF_WIDTH = pfa_pkg::REF_WIDTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [pfa_pkg::CFG_W-1:0] cfg_wdata_i,
  pfa_req_if.sink                  req_i,
  pfa_rsp_if.source                rsp_o
);
  import pfa_pkg::*;

  localparam int PAGE_W = $clog2(NUM_PAGES);
  localparam int TOP_W  = $clog2(NUM_PAGES + 1);
  localparam int META_W = REF_WIDTH + 1;
  localparam logic [PAGE_W-1:0] IDX_LAST = PAGE_W'(NUM_PAGES - 1);

  state_e                state_q, state_d;
  logic [PAGE_W-1:0]     idx_q, idx_d;
  logic [TOP_W-1:0]      top_q, top_d;
  cmd_e                  cmd_q, cmd_d;
  logic [PAGE_IDX_W-1:0] pg_q, pg_d;
  logic [CFG_W-1:0]      first_free_q;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [PAGE_IDX_W-1:0] out_page_q, out_page_d;
  logic [REF_OUT_W-1:0]  out_cnt_q, out_cnt_d;

  logic                  meta_we;
  logic [PAGE_W-1:0]     meta_waddr, meta_raddr;
  logic [META_W-1:0]     meta_wdata, meta_rdata;
  logic                  stk_we;
  logic [PAGE_W-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic                  cur_on;
  logic [REF_WIDTH-1:0]  cur_cnt, dec_cnt;
  logic [TOP_W-1:0]      ff_eff;
  logic [PAGE_W-1:0]     pg_addr;
  logic                  pg_in_range, stack_room, exec_go, in_ready, push_dec;

  pfa_ram #(.WIDTH(META_W), .DEPTH(NUM_PAGES)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rdata)
  );

  pfa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign cur_on      = meta_rdata[REF_WIDTH];
  assign cur_cnt     = meta_rdata[REF_WIDTH-1:0];
  assign dec_cnt     = cur_cnt - REF_WIDTH'(1);
  assign pg_addr     = PAGE_W'(pg_q);
  assign pg_in_range = 32'(pg_q) < NUM_PAGES;
  assign stack_room  = 32'(top_q) < NUM_PAGES;
  assign exec_go     = !out_valid_q || rsp_o.ready;
  assign ff_eff      = (32'(first_free_q) > NUM_PAGES) ? TOP_W'(NUM_PAGES)
                                                       : TOP_W'(first_free_q);
  assign push_dec    = (dec_cnt == '0) && !cur_on && stack_room;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    top_d        = top_q;
    cmd_d        = cmd_q;
    pg_d         = pg_q;
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_page_d   = out_page_q;
    out_cnt_d    = out_cnt_q;
    in_ready     = 1'b0;
    meta_we      = 1'b0;
    meta_waddr   = idx_q;
    meta_wdata   = '0;
    meta_raddr   = pg_addr;
    stk_we       = 1'b0;
    stk_waddr    = PAGE_W'(top_q);
    stk_wdata    = pg_addr;
    stk_raddr    = PAGE_W'(top_q - TOP_W'(1));

    unique case (state_q)
      ST_CLEAR: begin
        meta_we = 1'b1;
        idx_d   = idx_q + PAGE_W'(1);
        if (idx_q == IDX_LAST) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready   = 1'b1;
        meta_raddr = PAGE_W'(req_i.page_index);
        if (req_i.valid) begin
          cmd_d = cmd_e'(req_i.cmd);
          pg_d  = req_i.page_index;
          idx_d = '0;
          if (cmd_e'(req_i.cmd) == CMD_INIT) begin
            top_d   = '0;
            state_d = ST_INIT;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_INIT: begin
        meta_we = 1'b1;
        if (TOP_W'(idx_q) < ff_eff) begin
          meta_wdata = META_W'(1);
        end else begin
          meta_wdata = {1'b1, {REF_WIDTH{1'b0}}};
          stk_we     = 1'b1;
          stk_wdata  = idx_q;
          top_d      = top_q + TOP_W'(1);
        end
        idx_d = idx_q + PAGE_W'(1);
        if (idx_q == IDX_LAST) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_go) begin
          state_d      = ST_IDLE;
          out_valid_d  = 1'b1;
          out_status_d = STAT_OK;
          out_page_d   = pg_q;
          out_cnt_d    = '0;
          unique case (cmd_q)
            CMD_INIT: begin
              out_page_d = '0;
            end
            CMD_ALLOC: begin
              if (top_q == '0) begin
                out_status_d = STAT_NOMEM;
                out_page_d   = '0;
              end else begin
                top_d      = top_q - TOP_W'(1);
                meta_we    = 1'b1;
                meta_waddr = stk_rdata;
                out_page_d = PAGE_IDX_W'(stk_rdata);
              end
            end
            CMD_FREE: begin
              priority if (!pg_in_range) begin
                out_status_d = STAT_ALREADY_FREE;
              end else if (cur_on) begin
                out_status_d = STAT_ALREADY_FREE;
                out_cnt_d    = REF_OUT_W'(cur_cnt);
              end else if (cur_cnt != '0) begin
                out_status_d = STAT_REFERENCED;
                out_cnt_d    = REF_OUT_W'(cur_cnt);
              end else if (stack_room) begin
                meta_we    = 1'b1;
                meta_waddr = pg_addr;
                meta_wdata = {1'b1, {REF_WIDTH{1'b0}}};
                stk_we     = 1'b1;
                top_d      = top_q + TOP_W'(1);
              end
            end
            CMD_DECREF: begin
              priority if (!pg_in_range) begin
                out_status_d = STAT_ALREADY_FREE;
              end else if (cur_cnt == '0) begin
                out_status_d = STAT_UNDERFLOW;
              end else begin
                meta_we    = 1'b1;
                meta_waddr = pg_addr;
                meta_wdata = {cur_on | push_dec, dec_cnt};
                out_cnt_d  = REF_OUT_W'(dec_cnt);
                if (push_dec) begin
                  stk_we = 1'b1;
                  top_d  = top_q + TOP_W'(1);
                end
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      idx_q        <= '0;
      top_q        <= '0;
      cmd_q        <= CMD_INIT;
      out_valid_q  <= 1'b0;
      first_free_q <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      top_q       <= top_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        first_free_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q         <= pg_d;
    out_status_q <= out_status_d;
    out_page_q   <= out_page_d;
    out_cnt_q    <= out_cnt_d;
  end

  assign req_i.ready           = in_ready;
  assign rsp_o.valid           = out_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.result_page     = out_page_q;
  assign rsp_o.ref_count_after = out_cnt_q;

  a_top_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(top_q) <= NUM_PAGES)
    else $error("stack top beyond page count");

  a_alloc_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && exec_go && cmd_q == CMD_ALLOC && top_q != '0)
    |=> top_q == $past(top_q) - TOP_W'(1))
    else $error("alloc did not pop the stack");

  a_init_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INIT && idx_q == IDX_LAST)
    |=> 32'(top_q) == NUM_PAGES - 32'(ff_eff))
    else $error("init left wrong stack depth");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_EXEC))
    else $error("response raised outside execute step");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !out_valid_q && !in_ready)
    else $error("traffic during clearing pass");

endmodule

### test/page_frame_allocator_test.sv
// Self-checking testbench of the page frame allocator: directed table, then random phases.
`timescale 1ns / 1ps

module page_frame_allocator_test;
  import pfa_pkg::*;

  localparam int PAGES = NUM_PAGES_DEF;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 140;
  localparam int PLAN_ROWS = 24;
  localparam int HOLD_CYCLES = 64;

  typedef struct packed {
    status_e              status;
    logic [PAGE_IDX_W-1:0] page;
    logic [REF_OUT_W-1:0]  count;
  } outcome_t;

  typedef struct packed {
    cmd_e                  cmd;
    logic [PAGE_IDX_W-1:0] page;
    bit                    typed;
    outcome_t              result;
  } plan_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  pfa_req_if req_bus ();
  pfa_rsp_if rsp_bus ();

  page_frame_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .req_i       (req_bus),
    .rsp_o       (rsp_bus)
  );

  logic [REF_OUT_W-1:0]  page_refs [PAGES];
  logic [PAGE_IDX_W-1:0] free_pages [PAGES];
  bit                    page_listed [PAGES];
  int unsigned           free_depth;
  int unsigned           boundary;
  int unsigned           used_limit;
  logic [PAGE_IDX_W-1:0] lent_pages [$];

  outcome_t pending_results [$];
  int error_count;
  int requests_sent;
  int responses_seen;
  int status_tally [5];
  int random_inits;
  int send_idle_pct;
  int recv_idle_pct;
  int holds_asked = 0;
  int holds_done = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic void push_free_page(int unsigned pg);
    if (free_depth < PAGES) begin
      free_pages[free_depth] = pg[PAGE_IDX_W-1:0];
      free_depth++;
      page_listed[pg] = 1'b1;
    end
  endfunction

  function automatic outcome_t apply_request(cmd_e cmd, logic [PAGE_IDX_W-1:0] pg);
    outcome_t o;
    int unsigned top;
    o.status = STAT_OK;
    o.page = '0;
    o.count = '0;
    case (cmd)
      CMD_INIT: begin
        used_limit = (boundary > PAGES) ? PAGES : boundary;
        free_depth = 0;
        lent_pages.delete();
        for (int i = 0; i < PAGES; i++) begin
          page_listed[i] = 1'b0;
          if (i < used_limit) begin
            page_refs[i] = REF_OUT_W'(1);
          end else begin
            page_refs[i] = '0;
            push_free_page(i);
          end
        end
      end
      CMD_ALLOC: begin
        if (free_depth == 0) begin
          o.status = STAT_NOMEM;
        end else begin
          free_depth--;
          top = 32'(free_pages[free_depth]);
          page_listed[top] = 1'b0;
          page_refs[top] = '0;
          o.page = top[PAGE_IDX_W-1:0];
          lent_pages.push_back(top[PAGE_IDX_W-1:0]);
        end
      end
      CMD_FREE: begin
        o.page = pg;
        if (page_listed[pg]) begin
          o.status = STAT_ALREADY_FREE;
          o.count = page_refs[pg];
        end else if (page_refs[pg] != 0) begin
          o.status = STAT_REFERENCED;
          o.count = page_refs[pg];
        end else begin
          push_free_page(pg);
        end
      end
      default: begin
        o.page = pg;
        if (page_refs[pg] == 0) begin
          o.status = STAT_UNDERFLOW;
        end else begin
          page_refs[pg] = page_refs[pg] - REF_OUT_W'(1);
          if (page_refs[pg] == 0 && !page_listed[pg]) push_free_page(pg);
          o.count = page_refs[pg];
        end
      end
    endcase
    return o;
  endfunction

  task automatic send_request(cmd_e cmd, logic [PAGE_IDX_W-1:0] pg, bit typed,
                              outcome_t typed_result);
    outcome_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.cmd <= cmd;
    req_bus.page_index <= pg;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    predicted = apply_request(cmd, pg);
    pending_results.push_back(typed ? typed_result : predicted);
    requests_sent++;
  endtask

  task automatic wait_for_settle();
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_boundary(int unsigned value);
    cfg_we <= 1'b1;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    boundary = value;
  endtask

  function automatic logic [PAGE_IDX_W-1:0] take_lent_page();
    int idx;
    logic [PAGE_IDX_W-1:0] pg;
    idx = $urandom_range(lent_pages.size() - 1);
    pg = lent_pages[idx];
    lent_pages.delete(idx);
    return pg;
  endfunction

  task automatic issue_random();
    int pick;
    int sel;
    cmd_e cmd;
    logic [PAGE_IDX_W-1:0] pg;
    pick = $urandom_range(99);
    sel = $urandom_range(9);
    pg = PAGE_IDX_W'($urandom_range(PAGES - 1));
    if (pick < 1 && random_inits < 10) begin
      cmd = CMD_INIT;
      random_inits++;
    end else if (pick < 38) begin
      cmd = CMD_ALLOC;
    end else if (pick < 70) begin
      cmd = CMD_FREE;
      if (sel < 6 && lent_pages.size() != 0) pg = take_lent_page();
      else if (sel < 8 && used_limit > 0) pg = PAGE_IDX_W'($urandom_range(used_limit - 1));
    end else begin
      cmd = CMD_DECREF;
      if (sel < 5 && used_limit > 0) pg = PAGE_IDX_W'($urandom_range(used_limit - 1));
      else if (sel < 7 && lent_pages.size() != 0) pg = take_lent_page();
    end
    send_request(cmd, pg, 1'b0, '0);
  endtask

  initial begin
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        repeat (HOLD_CYCLES) begin
          rsp_bus.ready <= 1'b0;
          @(posedge clk);
        end
      end
      rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    outcome_t exp;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        responses_seen++;
        if (rsp_bus.status < 5) status_tally[rsp_bus.status]++;
        if (pending_results.size() == 0) begin
          $display("%0t: response with nothing pending: status %0d page %0d count %0d",
                   $time, rsp_bus.status, rsp_bus.result_page, rsp_bus.ref_count_after);
          error_count++;
        end else begin
          exp = pending_results.pop_front();
          if (rsp_bus.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status,
                     rsp_bus.status);
            error_count++;
          end
          if (rsp_bus.result_page !== exp.page) begin
            $display("%0t: result_page expected %0d actual %0d", $time, exp.page,
                     rsp_bus.result_page);
            error_count++;
          end
          if (rsp_bus.ref_count_after !== exp.count) begin
            $display("%0t: ref_count_after expected %0d actual %0d", $time, exp.count,
                     rsp_bus.ref_count_after);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    plan_row_t plan [PLAN_ROWS];
    int unsigned boundary_plan [PHASES];

    plan = '{
      '{CMD_ALLOC,  10'd0,    1'b1, '{STAT_NOMEM,        10'd0,    16'd0}},
      '{CMD_DECREF, 10'd5,    1'b1, '{STAT_UNDERFLOW,    10'd5,    16'd0}},
      '{CMD_FREE,   10'd1023, 1'b1, '{STAT_OK,           10'd1023, 16'd0}},
      '{CMD_FREE,   10'd1023, 1'b1, '{STAT_ALREADY_FREE, 10'd1023, 16'd0}},
      '{CMD_ALLOC,  10'd0,    1'b1, '{STAT_OK,           10'd1023, 16'd0}},
      '{CMD_INIT,   10'd0,    1'b1, '{STAT_OK,           10'd0,    16'd0}},
      '{CMD_ALLOC,  10'd0,    1'b1, '{STAT_OK,           10'd1023, 16'd0}},
      '{CMD_ALLOC,  10'd0,    1'b1, '{STAT_OK,           10'd1022, 16'd0}},
      '{CMD_ALLOC,  10'd0,    1'b1, '{STAT_NOMEM,        10'd0,    16'd0}},
      '{CMD_FREE,   10'd1023, 1'b1, '{STAT_OK,           10'd1023, 16'd0}},
      '{CMD_FREE,   10'd1023, 1'b1, '{STAT_ALREADY_FREE, 10'd1023, 16'd0}},
      '{CMD_FREE,   10'd0,    1'b1, '{STAT_REFERENCED,   10'd0,    16'd1}},
      '{CMD_DECREF, 10'd0,    1'b1, '{STAT_OK,           10'd0,    16'd0}},
      '{CMD_DECREF, 10'd0,    1'b1, '{STAT_UNDERFLOW,    10'd0,    16'd0}},
      '{CMD_FREE,   10'd0,    1'b1, '{STAT_ALREADY_FREE, 10'd0,    16'd0}},
      '{CMD_FREE,   10'h2AA,  1'b1, '{STAT_REFERENCED,   10'h2AA,  16'd1}},
      '{CMD_DECREF, 10'h155,  1'b1, '{STAT_OK,           10'h155,  16'd0}},
      '{CMD_ALLOC,  10'd0,    1'b0, '{STAT_OK,           10'd0,    16'd0}},
      '{CMD_ALLOC,  10'd0,    1'b0, '{STAT_OK,           10'd0,    16'd0}},
      '{CMD_ALLOC,  10'd0,    1'b0, '{STAT_OK,           10'd0,    16'd0}},
      '{CMD_ALLOC,  10'd0,    1'b0, '{STAT_OK,           10'd0,    16'd0}},
      '{CMD_DECREF, 10'd1021, 1'b1, '{STAT_OK,           10'd1021, 16'd0}},
      '{CMD_FREE,   10'd1022, 1'b0, '{STAT_OK,           10'd0,    16'd0}},
      '{CMD_ALLOC,  10'd0,    1'b0, '{STAT_OK,           10'd0,    16'd0}}
    };
    boundary_plan = '{0, 1000, 2047, 1024, 1012, 0};
    boundary_plan[PHASES-1] = $urandom_range(2047);

    error_count = 0;
    requests_sent = 0;
    responses_seen = 0;
    random_inits = 0;
    status_tally = '{default: 0};
    send_idle_pct = 35;
    recv_idle_pct = 48;
    boundary = 0;
    used_limit = 0;
    free_depth = 0;
    for (int i = 0; i < PAGES; i++) begin
      page_refs[i] = '0;
      page_listed[i] = 1'b0;
    end

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_bus.valid <= 1'b0;
    req_bus.cmd <= CMD_INIT;
    req_bus.page_index <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_boundary(1022);
    foreach (plan[r]) send_request(plan[r].cmd, plan[r].page, plan[r].typed, plan[r].result);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      wait_for_settle();
      set_boundary(boundary_plan[ph]);
      send_request(CMD_INIT, PAGE_IDX_W'($urandom_range(PAGES - 1)), 1'b0, '0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ((ph == 1 || ph == 4) && k == 20) holds_asked++;
        if (ph == 2 && k == 70) wait_for_settle();
        issue_random();
      end
    end

    wait_for_settle();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, pending_results.size());
      error_count++;
    end

    $display("Run covered %0d requests, %0d responses, %0d pool boundaries incl. 0 and 2047.",
             requests_sent, responses_seen, PHASES + 1);
    $display("Statuses: ok %0d, no memory %0d, referenced %0d, double free %0d, underflow %0d",
             status_tally[STAT_OK], status_tally[STAT_NOMEM], status_tally[STAT_REFERENCED],
             status_tally[STAT_ALREADY_FREE], status_tally[STAT_UNDERFLOW]);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
